### rtl/core/nqlv_pkg.sv
// Shared types and constants for the N-queens Las Vegas placer.
// Holds the generator constants, register indexes and the control/status bundles.
// No dependencies.
package nqlv_pkg;

    localparam int          DEF_MAX_N        = 16;
    localparam int          FIELD_W          = 5;
    localparam int          CFG_IDX_W        = 1;
    localparam int          CFG_DATA_W       = 32;
    localparam logic [31:0] LCG_MUL          = 32'd1194211693;
    localparam logic [31:0] LCG_ADD          = 32'd12345;
    localparam logic [4:0]  BOARD_SIZE_RESET = 5'd8;
    localparam logic [31:0] SEED_RESET       = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOARD_SIZE = 1'b0,
        REG_SEED       = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic init;
        logic scan;
        logic lcg_step;
        logic div_step;
        logic cand_rd;
        logic place;
        logic queen_rd;
        logic load_ok;
        logic load_fail;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic cnt_zero;
        logic div_last;
        logic row_last;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/core/nqlv_ctrl.sv
// Sequencing state machine of the N-queens placer: scan, draw, reduce, place, emit.
// Depends on nqlv_pkg for the command and status bundles.
module nqlv_ctrl
    import nqlv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       start_req,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_STEP    = 9'b000000100,
        S_DIV     = 9'b000001000,
        S_FETCH   = 9'b000010000,
        S_PLACE   = 9'b000100000,
        S_EMIT_RD = 9'b001000000,
        S_EMIT_LD = 9'b010000000,
        S_FAIL    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && start_req)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (status.cnt_zero)
                    state_next = S_FAIL;
                else
                begin
                    cmd.lcg_step = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.cand_rd = 1'b1;
                state_next  = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = status.row_last ? S_EMIT_RD : S_SCAN;
            end
            S_EMIT_RD:
            begin
                cmd.queen_rd = 1'b1;
                state_next   = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.load_ok = 1'b1;
                    state_next  = status.row_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_FAIL:
            begin
                if (status.out_free)
                begin
                    cmd.load_fail = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/nqlv_dp.sv
// Datapath of the N-queens placer: conflict masks, candidate and queen stores,
// generator, serial remainder unit, config registers and output register.
// Depends on nqlv_pkg.
module nqlv_dp
    import nqlv_pkg::*;
#(
    parameter int MAX_N = DEF_MAX_N
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FIELD_W-1:0]    row,
    output logic [FIELD_W-1:0]    column,
    output logic                  success,
    output logic                  last
);

    localparam int ROW_W = $clog2(MAX_N);
    localparam int CNT_W = $clog2(MAX_N + 1);

    logic [4:0]         bs_reg;
    logic [31:0]        lcg_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   col_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W:0]     rem_reg;
    logic [CNT_W:0]     rem_next;
    logic [3:0]         div_cnt_reg;
    logic [MAX_N-1:0]   cols_reg;
    logic [MAX_N-1:0]   ld_reg;
    logic [MAX_N-1:0]   rd_reg;
    logic [ROW_W-1:0]   cand_mem [MAX_N];
    logic [ROW_W-1:0]   queen_mem [MAX_N];
    logic [ROW_W-1:0]   cand_q_reg;
    logic [ROW_W-1:0]   queen_q_reg;
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_row_reg;
    logic [FIELD_W-1:0] out_col_reg;
    logic               out_success_reg;
    logic               out_last_reg;

    logic [ROW_W-1:0]   n_last;
    logic [MAX_N-1:0]   blocked;
    logic               col_safe;
    logic [MAX_N-1:0]   place_bit;
    logic [31:0]        lcg_prod;
    logic [15:0]        lcg_hi;
    logic [3:0]         bit_idx;
    logic [CNT_W:0]     rem_shift;
    logic               out_free;

    always_comb
    begin
        if (bs_reg == 5'd0)
            n_last = '0;
        else if ({1'b0, bs_reg} > 6'(MAX_N))
            n_last = ROW_W'(MAX_N - 1);
        else
            n_last = ROW_W'(bs_reg - 5'd1);
    end

    assign blocked   = cols_reg | ld_reg | rd_reg;
    assign col_safe  = ~blocked[col_reg];
    assign place_bit = {{(MAX_N-1){1'b0}}, 1'b1} << cand_q_reg;
    assign lcg_prod  = lcg_reg * LCG_MUL;
    assign lcg_hi    = lcg_reg[31:16];
    assign bit_idx   = ~div_cnt_reg;
    assign rem_shift = {rem_reg[CNT_W-1:0], lcg_hi[bit_idx]};
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (rem_shift >= {1'b0, cnt_reg})
            rem_next = rem_shift - {1'b0, cnt_reg};
        else
            rem_next = rem_shift;
    end

    assign status.scan_last = (col_reg == n_last);
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.div_last  = (div_cnt_reg == 4'hF);
    assign status.row_last  = (row_reg == n_last);
    assign status.out_free  = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg  <= BOARD_SIZE_RESET;
            lcg_reg <= SEED_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_BOARD_SIZE: bs_reg  <= cfg_data[4:0];
                    REG_SEED:       lcg_reg <= cfg_data;
                    default:        bs_reg  <= bs_reg;
                endcase
            end
            else if (cmd.lcg_step)
                lcg_reg <= lcg_prod + LCG_ADD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            cols_reg    <= '0;
            ld_reg      <= '0;
            rd_reg      <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                row_reg  <= '0;
                col_reg  <= '0;
                cnt_reg  <= '0;
                cols_reg <= '0;
                ld_reg   <= '0;
                rd_reg   <= '0;
            end
            if (cmd.scan)
            begin
                col_reg <= col_reg + 1'b1;
                if (col_safe)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.lcg_step)
            begin
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                rem_reg     <= rem_next;
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            if (cmd.place)
            begin
                cols_reg <= cols_reg | place_bit;
                ld_reg   <= (ld_reg | place_bit) << 1;
                rd_reg   <= (rd_reg | place_bit) >> 1;
                col_reg  <= '0;
                cnt_reg  <= '0;
                row_reg  <= status.row_last ? '0 : row_reg + 1'b1;
            end
            if (cmd.load_ok)
                row_reg <= row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && col_safe)
            cand_mem[cnt_reg[ROW_W-1:0]] <= col_reg;
        if (cmd.cand_rd)
            cand_q_reg <= cand_mem[rem_reg[ROW_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place)
            queen_mem[row_reg] <= cand_q_reg;
        if (cmd.queen_rd)
            queen_q_reg <= queen_mem[row_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_ok || cmd.load_fail)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_ok)
        begin
            out_row_reg     <= FIELD_W'({1'b0, row_reg} + 1'b1);
            out_col_reg     <= FIELD_W'({1'b0, queen_q_reg} + 1'b1);
            out_success_reg <= 1'b1;
            out_last_reg    <= status.row_last;
        end
        else if (cmd.load_fail)
        begin
            out_row_reg     <= FIELD_W'({1'b0, row_reg} + 1'b1);
            out_col_reg     <= '0;
            out_success_reg <= 1'b0;
            out_last_reg    <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = out_row_reg;
    assign column    = out_col_reg;
    assign success   = out_success_reg;
    assign last      = out_last_reg;

endmodule

### rtl/core/n_queens_las_vegas_placer.sv
// N-queens Las Vegas placer, top level. Depends on nqlv_pkg, nqlv_ctrl, nqlv_dp.
// Each attempt places one row at a time: it scans the N columns of the row, steps the
// generator, reduces its 16 high bits serially to a remainder, then fetches and places the
// chosen column; a failed attempt ends after a scan that finds no free column.
// Only one attempt runs at a time; the next start beat is taken once the last result
// sits in the output register. Reset clears control, board size to 8, generator to 1.
module n_queens_las_vegas_placer
    import nqlv_pkg::*;
#(
    parameter int MAX_N = DEF_MAX_N
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  start_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FIELD_W-1:0]    row,
    output logic [FIELD_W-1:0]    column,
    output logic                  success,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    nqlv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .start_req (start_req),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nqlv_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row       (row),
        .column    (column),
        .success   (success),
        .last      (last)
    );

endmodule

### rtl/core/nqlv_checker.sv
// Port-level checks for the N-queens placer, bound to the top level.
// Depends on nqlv_pkg.
module nqlv_checker
    import nqlv_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  start_req,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [FIELD_W-1:0]    row,
    input logic [FIELD_W-1:0]    column,
    input logic                  success,
    input logic                  last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row) && $stable(column)
            && $stable(success) && $stable(last))
        else $error("output beat changed while stalled");

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !success |-> last && column == '0)
        else $error("failure beat must be last with column zero");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && start_req |=> !in_ready)
        else $error("start beat did not occupy the placer");

    a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && success && !last |-> !in_ready)
        else $error("placer idle before last result beat");

endmodule

bind n_queens_las_vegas_placer nqlv_checker u_nqlv_checker (.*);
